FILE: design/tdrr_pkg.sv
// ----------------------------------------------------------------------------
// tdrr_pkg - touch report decode and remap, shared definitions
// Field widths, register indexes, rotation codes and the item/result types.
// ----------------------------------------------------------------------------
package tdrr_pkg;

    localparam int BURST_BYTES = 11;
    localparam int LAST_INDEX  = BURST_BYTES - 1;
    localparam int POS_W       = 4;
    localparam int COORD_W     = 12;
    localparam int ID_W        = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam int IN_DATA_W   = 8;
    localparam int IN_USER_W   = 2;

    localparam logic [COORD_W-1:0] X_MAX_RESET = 12'd319;
    localparam logic [COORD_W-1:0] Y_MAX_RESET = 12'd479;

    typedef logic [7:0] byte_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [ID_W-1:0] id_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROTATION     = 2'd0,
        CFG_REMAP_ENABLE = 2'd1,
        CFG_PANEL_X_MAX  = 2'd2,
        CFG_PANEL_Y_MAX  = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ROT_PORTRAIT         = 2'd0,
        ROT_LANDSCAPE        = 2'd1,
        ROT_PORTRAIT_FLIPPED = 2'd2,
        ROT_LANDSCAPE_FLIP   = 2'd3
    } rotation_t;

    typedef struct packed {
        rotation_t rotation;
        logic      remap_enable;
        coord_t    panel_x_max;
        coord_t    panel_y_max;
    } config_t;

    // first member sits in the top bits, so touched ends up at bit 0
    typedef struct packed {
        id_t        second_id;
        coord_t     second_y;
        coord_t     second_x;
        id_t        first_id;
        coord_t     first_y;
        coord_t     first_x;
        logic [1:0] touch_count;
        logic       touched;
    } result_t;

    localparam int RESULT_W   = $bits(result_t);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - RESULT_W;

    typedef struct packed {
        logic fire;   // item in the input register is consumed this cycle
        logic emit;   // the item in the input register gives a result
        logic abort;  // bus error: result is all zero
    } step_t;

    typedef struct packed {
        byte_t [BURST_BYTES-1:0] b;
    } burst_t;

endpackage

FILE: design/tdrr_capture.sv
// ----------------------------------------------------------------------------
// tdrr_capture - byte capture and burst position tracking
// Input register, position count and byte store; flags the last byte.
// ----------------------------------------------------------------------------
module tdrr_capture (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tdrr_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [tdrr_pkg::IN_USER_W-1:0]    s_tuser,
    input  logic                              out_free,
    output tdrr_pkg::step_t                   step,
    output tdrr_pkg::burst_t                  burst
);

    logic                           in_valid_reg, in_valid_next;
    tdrr_pkg::byte_t                in_byte_reg;
    logic                           in_start_reg;
    logic                           in_err_reg;
    logic [tdrr_pkg::POS_W-1:0]     pos_reg, pos_next;
    tdrr_pkg::byte_t                store_reg [tdrr_pkg::LAST_INDEX];

    logic [tdrr_pkg::POS_W-1:0]     idx;
    logic                           is_last;
    logic                           emit_cand;
    logic                           accept;

    always_comb begin
        if (in_start_reg || (pos_reg >= tdrr_pkg::POS_W'(tdrr_pkg::BURST_BYTES))) begin
            idx = '0;
        end else begin
            idx = pos_reg;
        end
    end

    assign is_last   = (idx == tdrr_pkg::POS_W'(tdrr_pkg::LAST_INDEX));
    assign emit_cand = in_err_reg || is_last;

    assign step.fire  = in_valid_reg && (!emit_cand || out_free);
    assign step.emit  = emit_cand;
    assign step.abort = in_err_reg;

    // a result-bearing item waits only while the result register is full and not taken
    assign s_tready = !in_valid_reg || !emit_cand || out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (step.fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb begin
        pos_next = pos_reg;
        if (step.fire) begin
            if (emit_cand) begin
                pos_next = '0;
            end else begin
                pos_next = idx + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            pos_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            pos_reg      <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
            in_err_reg   <= s_tuser[1];
        end
    end

    // the last byte is never stored: decode takes it straight from the input register
    always_ff @(posedge aclk) begin
        for (int i = 0; i < tdrr_pkg::LAST_INDEX; i++) begin
            if (step.fire && !emit_cand && (idx == tdrr_pkg::POS_W'(i))) begin
                store_reg[i] <= in_byte_reg;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < tdrr_pkg::LAST_INDEX; i++) begin
            burst.b[i] = store_reg[i];
        end
        burst.b[tdrr_pkg::LAST_INDEX] = in_byte_reg;
    end

endmodule

FILE: design/tdrr_decode.sv
// ----------------------------------------------------------------------------
// tdrr_decode - report unpack, id ordering and rotation remap
// Combinational decode of a complete burst into one result.
// ----------------------------------------------------------------------------
module tdrr_decode (
    input  tdrr_pkg::burst_t  burst,
    input  tdrr_pkg::config_t cfg,
    output tdrr_pkg::result_t result
);

    function automatic tdrr_pkg::coord_t flip_clamp(
        input tdrr_pkg::coord_t raw,
        input tdrr_pkg::coord_t max
    );
        return (raw <= max) ? (max - raw) : '0;
    endfunction

    function automatic logic [2*tdrr_pkg::COORD_W-1:0] map_point(
        input tdrr_pkg::coord_t  rx,
        input tdrr_pkg::coord_t  ry,
        input tdrr_pkg::config_t c
    );
        tdrr_pkg::coord_t sx;
        tdrr_pkg::coord_t sy;
        sx = rx;
        sy = ry;
        if (c.remap_enable) begin
            case (c.rotation)
                tdrr_pkg::ROT_LANDSCAPE: begin
                    sx = ry;
                    sy = flip_clamp(rx, c.panel_x_max);
                end
                tdrr_pkg::ROT_PORTRAIT_FLIPPED: begin
                    sx = flip_clamp(rx, c.panel_x_max);
                    sy = flip_clamp(ry, c.panel_y_max);
                end
                tdrr_pkg::ROT_LANDSCAPE_FLIP: begin
                    sx = flip_clamp(ry, c.panel_y_max);
                    sy = rx;
                end
                default: begin
                    sx = rx;
                    sy = ry;
                end
            endcase
        end
        return {sy, sx};
    endfunction

    logic [3:0]        count;
    logic              valid_count;
    logic              two;
    tdrr_pkg::coord_t  ax, ay, bx, by;
    tdrr_pkg::id_t     aid, bid;
    tdrr_pkg::coord_t  lo_x, lo_y, hi_x, hi_y;
    tdrr_pkg::id_t     lo_id, hi_id;
    logic              swap;
    logic [2*tdrr_pkg::COORD_W-1:0] lo_map, hi_map;

    assign count       = burst.b[0][3:0];
    assign valid_count = (count == 4'd1) || (count == 4'd2);
    assign two         = (count == 4'd2);

    assign ax  = {burst.b[1][3:0], burst.b[2]};
    assign ay  = {burst.b[3][3:0], burst.b[4]};
    assign aid = burst.b[3][7:4];
    assign bx  = {burst.b[7][3:0], burst.b[8]};
    assign by  = {burst.b[9][3:0], burst.b[10]};
    assign bid = burst.b[9][7:4];

    assign swap  = two && (aid > bid);
    assign lo_x  = swap ? bx  : ax;
    assign lo_y  = swap ? by  : ay;
    assign lo_id = swap ? bid : aid;
    assign hi_x  = swap ? ax  : bx;
    assign hi_y  = swap ? ay  : by;
    assign hi_id = swap ? aid : bid;

    assign lo_map = map_point(lo_x, lo_y, cfg);
    assign hi_map = map_point(hi_x, hi_y, cfg);

    always_comb begin
        result = '0;
        if (valid_count) begin
            result.touched     = 1'b1;
            result.touch_count = count[1:0];
            result.first_x     = lo_map[tdrr_pkg::COORD_W-1:0];
            result.first_y     = lo_map[2*tdrr_pkg::COORD_W-1:tdrr_pkg::COORD_W];
            result.first_id    = lo_id;
            if (two) begin
                result.second_x  = hi_map[tdrr_pkg::COORD_W-1:0];
                result.second_y  = hi_map[2*tdrr_pkg::COORD_W-1:tdrr_pkg::COORD_W];
                result.second_id = hi_id;
            end
        end
    end

endmodule

FILE: design/touch_report_decode_remap_core.sv
// ----------------------------------------------------------------------------
// touch_report_decode_remap_core - touch report decoder with rotation remap
// Takes report bytes one per item and gives one result per burst or bus error.
// ----------------------------------------------------------------------------
// Path: the last byte (or errored byte) of a burst is accepted into the input register,
// then decoded into the result register, which drives the master side.
// Throughput: one byte per cycle; a result-bearing byte waits only while the
// result register holds a result that is not being taken.
// Reset (aresetn low, synchronous): clears valids and position, and loads the
// configuration defaults (rotation 1, remap on, X max 319, Y max 479).
module touch_report_decode_remap_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tdrr_pkg::IN_DATA_W-1:0]      s_tdata,   // [7:0] report_byte
    input  logic [tdrr_pkg::IN_USER_W-1:0]      s_tuser,   // [0] start_of_burst, [1] bus_error
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] touched, [2:1] touch_count, [14:3] first_x, [26:15] first_y,
    // [30:27] first_id, [42:31] second_x, [54:43] second_y, [58:55] second_id
    output logic [tdrr_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_we,
    input  logic [tdrr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tdrr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    tdrr_pkg::config_t  cfg_reg;
    tdrr_pkg::step_t    step;
    tdrr_pkg::burst_t   burst;
    tdrr_pkg::result_t  decoded;
    tdrr_pkg::result_t  result_reg, result_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rotation     <= tdrr_pkg::ROT_LANDSCAPE;
            cfg_reg.remap_enable <= 1'b1;
            cfg_reg.panel_x_max  <= tdrr_pkg::X_MAX_RESET;
            cfg_reg.panel_y_max  <= tdrr_pkg::Y_MAX_RESET;
        end else if (cfg_we) begin
            case (tdrr_pkg::cfg_index_t'(cfg_index))
                tdrr_pkg::CFG_ROTATION:
                    cfg_reg.rotation <= tdrr_pkg::rotation_t'(cfg_wdata[1:0]);
                tdrr_pkg::CFG_REMAP_ENABLE:
                    cfg_reg.remap_enable <= cfg_wdata[0];
                tdrr_pkg::CFG_PANEL_X_MAX:
                    cfg_reg.panel_x_max <= cfg_wdata;
                tdrr_pkg::CFG_PANEL_Y_MAX:
                    cfg_reg.panel_y_max <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    tdrr_capture u_capture (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .out_free (out_free),
        .step     (step),
        .burst    (burst)
    );

    tdrr_decode u_decode (
        .burst  (burst),
        .cfg    (cfg_reg),
        .result (decoded)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        result_next  = result_reg;
        if (step.fire && step.emit) begin
            m_valid_next = 1'b1;
            result_next  = step.abort ? '0 : decoded;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{tdrr_pkg::OUT_PAD_W{1'b0}}, result_reg};

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench - touch report decode and remap core
// Streams report bytes into the core, decodes every burst in a local model of
// the report format and rotation remap, and checks each result on the master
// side field by field. A short table of directed items comes first, then
// random bursts (well-formed, truncated, restarted, aborted) over a sweep of
// register settings, with random idling on both sides and one long stall.
// ----------------------------------------------------------------------------
module testbench;
    import tdrr_pkg::*;

    localparam int ITEM_TARGET = 1750;
    localparam int PHASES      = 10;
    localparam int IDLE_PCT    = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 4;
    localparam int MAX_PRINTS  = 30;

    typedef struct packed {
        byte_t   b;
        logic    sob;
        logic    err;
        logic    pin;   // expected result typed below rather than predicted
        result_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 27;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{8'hFF, 1'b1, 1'b1, 1'b1, '0},   // bus error with start set
        '{8'h02, 1'b1, 1'b0, 1'b0, '0},   // two points, ids out of order
        '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{8'hF1, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, 1'b0, '0},
        '{8'hA0, 1'b0, 1'b0, 1'b0, '0},
        '{8'h01, 1'b1, 1'b0, 1'b0, '0},   // restart, then abort mid-burst
        '{8'h55, 1'b0, 1'b0, 1'b0, '0},
        '{8'hAA, 1'b0, 1'b0, 1'b0, '0},
        '{8'h0F, 1'b0, 1'b1, 1'b1, '0},
        '{8'hF3, 1'b1, 1'b0, 1'b0, '0},   // count 3: no touch
        '{8'h80, 1'b0, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, 1'b1, '0}
    };

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic [IN_USER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    touch_report_decode_remap_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // model state: burst bytes, fill position and register copy
    byte_t            held_bytes [BURST_BYTES];
    logic [POS_W-1:0] fill_pos;
    config_t          cfg;

    result_t  pending_reports [$];
    dir_row_t typed_rows [$];

    bit steady;
    bit hold_req;
    int hold_left;
    int quiet_cycles;
    int mismatches;
    int items_sent, items_taken, results_seen;
    int n_double, n_single, n_empty, n_errors, n_settings;

    initial begin
        aclk = 1'b0;
    end
    always #2 aclk = ~aclk;

    function automatic coord_t flipped(coord_t raw, coord_t lim);
        return (raw <= lim) ? coord_t'(lim - raw) : '0;
    endfunction

    function automatic void place_point(input coord_t rx, input coord_t ry,
                                        output coord_t sx, output coord_t sy);
        sx = rx;
        sy = ry;
        if (cfg.remap_enable) begin
            case (cfg.rotation)
                ROT_LANDSCAPE: begin
                    sx = ry;
                    sy = flipped(rx, cfg.panel_x_max);
                end
                ROT_PORTRAIT_FLIPPED: begin
                    sx = flipped(rx, cfg.panel_x_max);
                    sy = flipped(ry, cfg.panel_y_max);
                end
                ROT_LANDSCAPE_FLIP: begin
                    sx = flipped(ry, cfg.panel_y_max);
                    sy = rx;
                end
                default: ;
            endcase
        end
    endfunction

    function automatic result_t decode_burst();
        result_t    r;
        logic [3:0] cnt;
        coord_t     ax, ay, bx, by, tx, ty;
        id_t        aid, bid, tid;
        r   = '0;
        cnt = held_bytes[0][3:0];
        if (cnt == 4'd0 || cnt > 4'd2)
            return r;
        r.touched     = 1'b1;
        r.touch_count = cnt[1:0];
        ax  = {held_bytes[1][3:0], held_bytes[2]};
        ay  = {held_bytes[3][3:0], held_bytes[4]};
        aid = held_bytes[3][7:4];
        if (cnt == 4'd2) begin
            bx  = {held_bytes[7][3:0], held_bytes[8]};
            by  = {held_bytes[9][3:0], held_bytes[10]};
            bid = held_bytes[9][7:4];
            if (aid > bid) begin
                tx = ax;   ax = bx;   bx = tx;
                ty = ay;   ay = by;   by = ty;
                tid = aid; aid = bid; bid = tid;
            end
            place_point(bx, by, tx, ty);
            r.second_x  = tx;
            r.second_y  = ty;
            r.second_id = bid;
        end
        place_point(ax, ay, tx, ty);
        r.first_x  = tx;
        r.first_y  = ty;
        r.first_id = aid;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     results_seen, what, got, want);
    endtask

    // one accepted item: update the burst image, queue a result if it ends one
    task automatic take_item(input byte_t b, input logic sob, input logic err);
        dir_row_t row;
        bit       emits;
        result_t  r;
        int       idx;
        row   = '0;
        emits = 1'b0;
        r     = '0;
        if (typed_rows.size() != 0)
            row = typed_rows.pop_front();
        items_taken++;
        if (err) begin
            fill_pos = '0;
            emits    = 1'b1;
            n_errors++;
        end else begin
            idx = sob ? 0 : int'(fill_pos);
            if (idx >= BURST_BYTES)
                idx = 0;
            held_bytes[idx] = b;
            if (idx == LAST_INDEX) begin
                fill_pos = '0;
                emits    = 1'b1;
                r        = decode_burst();
            end else begin
                fill_pos = POS_W'(idx + 1);
            end
        end
        if (emits)
            pending_reports.push_back(row.pin ? row.want : r);
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] word);
        result_t got, want;
        got = result_t'(word[RESULT_W-1:0]);
        results_seen++;
        if (pending_reports.size() == 0) begin
            flag_mismatch("unexpected result", word, 0);
            return;
        end
        want = pending_reports.pop_front();
        if (!want.touched)
            n_empty++;
        else if (want.touch_count == 2'd2)
            n_double++;
        else
            n_single++;
        if (word[OUT_DATA_W-1:RESULT_W] != '0)
            flag_mismatch("pad bits", word[OUT_DATA_W-1:RESULT_W], 0);
        if (got.touched != want.touched)
            flag_mismatch("touched", got.touched, want.touched);
        if (got.touch_count != want.touch_count)
            flag_mismatch("touch_count", got.touch_count, want.touch_count);
        if (got.first_x != want.first_x)
            flag_mismatch("first_x", got.first_x, want.first_x);
        if (got.first_y != want.first_y)
            flag_mismatch("first_y", got.first_y, want.first_y);
        if (got.first_id != want.first_id)
            flag_mismatch("first_id", got.first_id, want.first_id);
        if (got.second_x != want.second_x)
            flag_mismatch("second_x", got.second_x, want.second_x);
        if (got.second_y != want.second_y)
            flag_mismatch("second_y", got.second_y, want.second_y);
        if (got.second_id != want.second_id)
            flag_mismatch("second_id", got.second_id, want.second_id);
    endtask

    // everything is sampled at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg.rotation     = ROT_LANDSCAPE;
            cfg.remap_enable = 1'b1;
            cfg.panel_x_max  = X_MAX_RESET;
            cfg.panel_y_max  = Y_MAX_RESET;
            fill_pos         = '0;
            quiet_cycles     = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_ROTATION:     cfg.rotation     = rotation_t'(cfg_wdata[1:0]);
                    CFG_REMAP_ENABLE: cfg.remap_enable = cfg_wdata[0];
                    CFG_PANEL_X_MAX:  cfg.panel_x_max  = cfg_wdata;
                    CFG_PANEL_Y_MAX:  cfg.panel_y_max  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_item(s_tdata, s_tuser[0], s_tuser[1]);
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                $display("touch_report_decode_remap_core verification failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold counted here
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic push_byte(input byte_t b, input logic sob, input logic err);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = {err, sob};
        items_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // stop offering, wait for every expected result, then let the pipe empty
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    function automatic coord_t pick_coord(coord_t lim);
        case ($urandom_range(4))
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, int'(lim)));
            2: return lim;
            3: return coord_t'(lim + 1'b1);
            default: return $urandom_range(1) ? '1 : '0;
        endcase
    endfunction

    task automatic random_burst();
        byte_t      img [BURST_BYTES];
        coord_t     ax, ay, bx, by;
        id_t        aid, bid;
        logic [3:0] cnt;
        int         kind, cut, sel;
        kind = $urandom_range(99);
        sel  = $urandom_range(9);
        if (sel < 4)       cnt = 4'd1;
        else if (sel < 8)  cnt = 4'd2;
        else if (sel == 8) cnt = 4'd0;
        else               cnt = 4'($urandom_range(3, 15));
        aid = id_t'($urandom);
        bid = ($urandom_range(7) == 0) ? aid : id_t'($urandom);
        ax  = pick_coord(cfg.panel_x_max);
        ay  = pick_coord(cfg.panel_y_max);
        bx  = pick_coord(cfg.panel_x_max);
        by  = pick_coord(cfg.panel_y_max);
        img[0]  = {4'($urandom), cnt};
        img[1]  = {4'($urandom), ax[11:8]};
        img[2]  = ax[7:0];
        img[3]  = {aid, ay[11:8]};
        img[4]  = ay[7:0];
        img[5]  = byte_t'($urandom);
        img[6]  = byte_t'($urandom);
        img[7]  = {4'($urandom), bx[11:8]};
        img[8]  = bx[7:0];
        img[9]  = {bid, by[11:8]};
        img[10] = by[7:0];
        cut = $urandom_range(0, LAST_INDEX - 1);
        if (kind < 80) begin
            for (int i = 0; i < BURST_BYTES; i++)
                push_byte(img[i], i == 0, 1'b0);
        end else if (kind < 88) begin
            // aborted part way
            for (int i = 0; i <= cut; i++)
                push_byte(img[i], i == 0, 1'b0);
            push_byte(byte_t'($urandom), 1'($urandom), 1'b1);
        end else if (kind < 94) begin
            // truncated; the next start restarts the count
            for (int i = 0; i <= cut; i++)
                push_byte(img[i], i == 0, 1'b0);
        end else if (kind < 97) begin
            push_byte(byte_t'($urandom), 1'($urandom), 1'b1);
        end else begin
            // bytes with no start marker, continuing from wherever the count is
            for (int i = 0; i <= cut + 1; i++)
                push_byte(byte_t'($urandom), 1'b0, 1'b0);
        end
    endtask

    initial begin
        rotation_t             rot;
        logic                  remap;
        logic [CFG_DATA_W-1:0] xm, ym;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        steady    = 1'b0;
        hold_req  = 1'b0;
        hold_left = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // directed rows run on the reset register values
        foreach (DIRECTED[i]) begin
            typed_rows.push_back(DIRECTED[i]);
            push_byte(DIRECTED[i].b, DIRECTED[i].sob, DIRECTED[i].err);
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            rot   = rotation_t'($urandom_range(3));
            remap = 1'b1;
            xm    = CFG_DATA_W'($urandom);
            ym    = CFG_DATA_W'($urandom);
            case (p)
                0: begin rot = ROT_PORTRAIT;         xm = 12'd319;  ym = 12'd479;  end
                1: begin rot = ROT_LANDSCAPE;        xm = 12'd4095; ym = 12'd4095; end
                2: begin rot = ROT_PORTRAIT_FLIPPED; xm = 12'd319;  ym = 12'd479;  end
                3: begin rot = ROT_LANDSCAPE_FLIP;   xm = 12'd100;  ym = 12'd200;  end
                4: remap = 1'b0;
                5: begin rot = ROT_PORTRAIT_FLIPPED; xm = 12'd0;    ym = 12'd0;    end
                6: begin rot = ROT_LANDSCAPE_FLIP;   xm = 12'd0;    ym = 12'd4095; end
                7: begin rot = ROT_LANDSCAPE;        xm = 12'd4095; ym = 12'd0;    end
                default: remap = 1'($urandom);
            endcase
            // upper data bits are don't-care for the narrow registers
            write_reg(CFG_ROTATION, {10'($urandom), rot});
            write_reg(CFG_REMAP_ENABLE, {11'($urandom), remap});
            write_reg(CFG_PANEL_X_MAX, xm);
            write_reg(CFG_PANEL_Y_MAX, ym);
            n_settings++;
            steady = (p == 2);
            if (p == 3)
                hold_req = 1'b1;
            while (items_sent < DIR_ROWS + (p + 1) * (ITEM_TARGET / PHASES))
                random_burst();
        end
        steady = 1'b0;

        settle();
        repeat (8) @(posedge aclk);
        if (pending_reports.size() != 0)
            flag_mismatch("results never delivered", pending_reports.size(), 0);
        $display("%0d items accepted, %0d results checked: %0d double, %0d single, %0d empty",
                 items_taken, results_seen, n_double, n_single, n_empty);
        $display("%0d register settings, %0d bus errors, one %0d-cycle output stall",
                 n_settings, n_errors, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("touch_report_decode_remap_core verification clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("touch_report_decode_remap_core verification failed");
        end
        $finish;
    end

endmodule
